### rtl/pwmda_pkg.sv
// ----------------------------------------------------------------------------
// pwmda_pkg
// Shared types and constants of the PWM duty demodulator with averaging.
// ----------------------------------------------------------------------------
package pwmda_pkg;

  localparam int unsigned SAMPLE_W       = 10;
  localparam int unsigned TICK_W         = 8;
  localparam int unsigned TS_W           = 32;
  localparam int unsigned PADDR_W        = 3;
  localparam int unsigned PDATA_W        = 32;
  localparam int unsigned RING_DEPTH_DEF = 10;
  localparam int unsigned STAMP_BITS_DEF = 32;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 10'd620;
  localparam logic [TICK_W-1:0]   TICKS_RST      = 8'd5;

  typedef enum logic [1:0] {
    FUNC_RISE = 2'd0,
    FUNC_FALL = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic {
    REG_FULL_SCALE = 1'b0,
    REG_TICKS      = 1'b1
  } reg_e;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

### rtl/pwm_duty_demodulator_average_top.sv
// ----------------------------------------------------------------------------
// pwm_duty_demodulator_average_top
// PWM duty capture from edge timestamps with a moving-average DAC output.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   func_i, timestamp_i
//   out      output     out_valid_o / out_stall_i dac_value_o
//   cfg      input      APB psel/penable/pwrite   paddr, pwdata, prdata
//
// Falling edges, ignored codes and non-updating ticks are taken in idle. A
// rising edge with a sample: serial multiply (ST_MUL), serial divide of
// STAMP_BITS+SAMPLE_W bits (ST_DIV_GO, ST_DIV), ST_COMMIT. Updating tick:
// serial divide (ST_DIV), then ST_AVG_OUT, which waits under output stall.
// Reset clears all state at once; no clearing pass. The output register
// holds a result under stall while the next transaction is taken.
// ----------------------------------------------------------------------------
module pwm_duty_demodulator_average_top
  import pwmda_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [TS_W-1:0]     timestamp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SAMPLE_W-1:0] dac_value_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int unsigned PTR_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned SUM_W    = SAMPLE_W + $clog2(RING_DEPTH);
  localparam int unsigned DVD_W    = STAMP_BITS + SAMPLE_W;
  localparam int unsigned MCNT_W   = $clog2(SAMPLE_W);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(RING_DEPTH * ((1 << SAMPLE_W) - 1));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV,
    ST_COMMIT,
    ST_AVG_OUT
  } state_e;

  state_e                state_q;
  logic [SAMPLE_W-1:0]   full_scale_q;
  logic [TICK_W-1:0]     ticks_q;
  logic [STAMP_BITS-1:0] rise_time_q;
  logic                  rise_seen_q;
  logic [STAMP_BITS-1:0] high_q;
  logic [PTR_W-1:0]      ptr_q;
  logic [TICK_W-1:0]     tick_q;
  logic [SUM_W-1:0]      sum_q;
  logic [SUM_W-1:0]      sum_d;
  logic [RING_DEPTH-1:0] vld_q;
  logic                  out_valid_q;
  logic                  avg_q;
  logic [MCNT_W-1:0]     mul_cnt_q;
  logic [STAMP_BITS-1:0] period_q;
  logic [STAMP_BITS-1:0] period_d;
  logic [DVD_W-1:0]      acc_q;
  logic [DVD_W-1:0]      acc_d;
  logic [SAMPLE_W-1:0]   fs_sh_q;
  logic [SAMPLE_W-1:0]   dac_q;

  logic [STAMP_BITS-1:0] ts;
  logic                  in_acc;
  logic                  cfg_wr;
  logic [TICK_W:0]       tick_cnt;
  logic [TICK_W:0]       tick_lim;
  logic                  tick_emit;
  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [STAMP_BITS-1:0] div_dsr;
  logic [SAMPLE_W-1:0]   div_quot;
  div_stat_t             div_stat;
  logic [SAMPLE_W-1:0]   ram_rdata;
  logic [SAMPLE_W-1:0]   old_sample;
  logic [SAMPLE_W-1:0]   sample;
  logic [PTR_W-1:0]      ptr_nxt;
  logic                  ram_we;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RST;
      ticks_q      <= TICKS_RST;
    end else if (cfg_wr) begin
      unique case (reg_e'(paddr[2]))
        REG_FULL_SCALE: full_scale_q <= pwdata[SAMPLE_W-1:0];
        REG_TICKS:      ticks_q      <= pwdata[TICK_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_FULL_SCALE: prdata = PDATA_W'(full_scale_q);
      REG_TICKS:      prdata = PDATA_W'(ticks_q);
      default:        prdata = '0;
    endcase
  end

  // datapath
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign ts         = timestamp_i[STAMP_BITS-1:0];
  assign period_d   = ts - rise_time_q;

  assign tick_cnt  = {1'b0, tick_q} + 1'b1;
  assign tick_lim  = (ticks_q == '0) ? {1'b1, {TICK_W{1'b0}}} : {1'b0, ticks_q};
  assign tick_emit = (tick_cnt >= tick_lim);

  assign acc_d = {acc_q[DVD_W-2:0], 1'b0} +
                 (fs_sh_q[SAMPLE_W-1] ? {{SAMPLE_W{1'b0}}, high_q} : '0);

  assign div_start = (state_q == ST_DIV_GO) ||
                     (in_acc && func_e'(func_i) == FUNC_TICK && tick_emit);
  assign div_dvd   = (state_q == ST_DIV_GO) ? acc_q : DVD_W'(sum_q);
  assign div_dsr   = (state_q == ST_DIV_GO) ? period_q : STAMP_BITS'(RING_DEPTH);

  assign old_sample = vld_q[ptr_q] ? ram_rdata : '0;
  assign sample     = (div_stat.ovf || div_quot > full_scale_q) ? full_scale_q : div_quot;
  assign sum_d      = sum_q - SUM_W'(old_sample) + SUM_W'(sample);
  assign ptr_nxt    = (ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign ram_we     = (state_q == ST_COMMIT);

  pwmda_div #(
    .DSR_W(STAMP_BITS),
    .DVD_W(DVD_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .quot_o    (div_quot),
    .stat_o    (div_stat)
  );

  pwmda_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ptr_q),
    .wdata_i(sample),
    .raddr_i(ptr_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rise_time_q <= '0;
      rise_seen_q <= 1'b0;
      high_q      <= '0;
      ptr_q       <= '0;
      tick_q      <= '0;
      sum_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      avg_q       <= 1'b0;
      mul_cnt_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_AVG_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (func_e'(func_i))
              FUNC_RISE: begin
                if (rise_seen_q && period_d != '0) begin
                  mul_cnt_q <= MCNT_W'(SAMPLE_W - 1);
                  state_q   <= ST_MUL;
                end
                rise_time_q <= ts;
                rise_seen_q <= 1'b1;
              end
              FUNC_FALL: high_q <= period_d;
              FUNC_TICK: begin
                if (tick_emit) begin
                  tick_q  <= '0;
                  avg_q   <= 1'b1;
                  state_q <= ST_DIV;
                end else begin
                  tick_q <= tick_cnt[TICK_W-1:0];
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          mul_cnt_q <= mul_cnt_q - 1'b1;
          if (mul_cnt_q == '0) begin
            state_q <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          avg_q   <= 1'b0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_q <= avg_q ? ST_AVG_OUT : ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          vld_q[ptr_q] <= 1'b1;
          sum_q        <= sum_d;
          ptr_q        <= ptr_nxt;
          state_q      <= ST_IDLE;
        end
        ST_AVG_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && func_e'(func_i) == FUNC_RISE) begin
      period_q <= period_d;
      acc_q    <= '0;
      fs_sh_q  <= full_scale_q;
    end else if (state_q == ST_MUL) begin
      acc_q   <= acc_d;
      fs_sh_q <= {fs_sh_q[SAMPLE_W-2:0], 1'b0};
    end
    if (state_q == ST_AVG_OUT && (!out_valid_q || !out_stall_i)) begin
      dac_q <= div_quot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_value_o = dac_q;

  // checks
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_MAX)
    else $error("ring sum above its bound");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(RING_DEPTH - 1))
    else $error("ring pointer out of range");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == ST_DIV)
    else $error("divider finished outside of the divide state");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_AVG_OUT))
    else $error("output raised without an average");

endmodule

### rtl/pwmda_ram.sv
// ----------------------------------------------------------------------------
// pwmda_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pwmda_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 10,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/pwmda_div.sv
// ----------------------------------------------------------------------------
// pwmda_div
// Bit-serial restoring divider, one dividend bit per cycle. Keeps the low
// quotient bits and a sticky flag for any quotient bit above them.
// ----------------------------------------------------------------------------
module pwmda_div
  import pwmda_pkg::*;
#(
  parameter int unsigned DSR_W = STAMP_BITS_DEF,
  parameter int unsigned DVD_W = STAMP_BITS_DEF + SAMPLE_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DVD_W-1:0]    dividend_i,
  input  logic [DSR_W-1:0]    divisor_i,
  output logic [SAMPLE_W-1:0] quot_o,
  output div_stat_t           stat_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]    cnt_q;
  logic                done_q;
  logic                ovf_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [DSR_W-1:0]    dsr_q;
  logic [DSR_W-1:0]    rem_q;
  logic [SAMPLE_W-1:0] quot_q;

  logic [DSR_W:0]      trial;
  logic [DSR_W:0]      diff;
  logic                ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(DVD_W);
        ovf_q <= 1'b0;
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        ovf_q  <= ovf_q | quot_q[SAMPLE_W-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
      rem_q  <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quot_q <= {quot_q[SAMPLE_W-2:0], ge};
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule
